FILE: rtl/rfq_pkg.sv
// Package with operation codes, status codes and shared types of the reversible queue.
`timescale 1ns / 1ps
package rfq_pkg;

	localparam logic [1:0] OP_ENQUEUE = 2'd0;
	localparam logic [1:0] OP_DEQUEUE = 2'd1;
	localparam logic [1:0] OP_PEEK    = 2'd2;
	localparam logic [1:0] OP_REVERSE = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		logic    valid;
		logic    rd;
		status_t status;
		logic    is_empty;
		count_t  count;
	} result_t;

endpackage

FILE: rtl/rfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rfq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/rfq_ctrl.sv
// Pointer, occupancy and direction control of the reversible queue, with the result register.
`timescale 1ns / 1ps
module rfq_ctrl import rfq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  op_t                            op,
	input  value_t                         value,
	input  logic                           out_ready,
	output logic                           ram_we,
	output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
	output value_t                         ram_wdata,
	output logic                           ram_re,
	output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
	output result_t                        res_s1
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	logic [IDX_W-1:0] head_q, tail_q, head_n, tail_n;
	logic [IDX_W-1:0] head_prev, tail_prev, head_next, tail_next;
	logic [CNT_W-1:0] occ_q, occ_n;
	logic             rev_q, rev_n;
	logic             accept, full, empty, we, re;
	status_t          status;

	assign accept    = in_valid && in_ready;
	assign in_ready  = !res_s1.valid || out_ready;
	assign full      = (occ_q == FULL_CNT);
	assign empty     = (occ_q == '0);
	assign head_prev = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign tail_prev = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;

	always_comb begin
		head_n    = head_q;
		tail_n    = tail_q;
		occ_n     = occ_q;
		rev_n     = rev_q;
		we        = 1'b0;
		re        = 1'b0;
		status    = ST_OK;
		ram_waddr = rev_q ? head_prev : tail_q;
		ram_raddr = rev_q ? tail_prev : head_q;
		unique case (op)
			OP_ENQUEUE: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					we    = 1'b1;
					occ_n = occ_q + 1'b1;
					if (rev_q) begin
						head_n = head_prev;
					end else begin
						tail_n = tail_next;
					end
				end
			end
			OP_DEQUEUE: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					re    = 1'b1;
					occ_n = occ_q - 1'b1;
					if (rev_q) begin
						tail_n = tail_prev;
					end else begin
						head_n = head_next;
					end
				end
			end
			OP_PEEK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					re = 1'b1;
				end
			end
			default: begin
				if (!empty) begin
					rev_n = ~rev_q;
				end
			end
		endcase
	end

	assign ram_we    = accept && we;
	assign ram_re    = accept && re;
	assign ram_wdata = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
			rev_q  <= 1'b0;
			res_s1 <= '0;
		end else begin
			if (accept) begin
				head_q          <= head_n;
				tail_q          <= tail_n;
				occ_q           <= occ_n;
				rev_q           <= rev_n;
				res_s1.valid    <= 1'b1;
				res_s1.rd       <= re;
				res_s1.status   <= status;
				res_s1.is_empty <= (occ_n == '0);
				res_s1.count    <= COUNT_W'(occ_n);
			end else if (out_ready) begin
				res_s1.valid <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/reversible_fifo_queue.sv
// Top level of the reversible FIFO queue: stream ports, control and entry store.
`timescale 1ns / 1ps
// Bounded FIFO of signed 32-bit values with enqueue, dequeue, peek and a one-step
// reverse. One operation is taken per cycle unless output stalls; its result appears
// in the next cycle from the result register. At most one store access per operation
// (one write or one registered read of the entry RAM) sets that rate. Each operation
// gives exactly one result: the value read (zero when nothing is read), a status, an
// empty flag and the entry count masked to five bits. Enqueue when full drops the value
// with full status; dequeue or peek when empty reports empty status. The input side
// stays ready while a result waits, as long as the result is taken in the same cycle.
module reversible_fifo_queue import rfq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // read_value[31:0], is_empty[32], entry_count[37:33], zero
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	value_t           ram_wdata, ram_rdata, read_value;
	result_t          res_s1;

	rfq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.op       (s_tuser),
		.value    (s_tdata),
		.out_ready(m_tready),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.res_s1   (res_s1)
	);

	rfq_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign read_value = res_s1.rd ? ram_rdata : '0;
	assign m_tvalid   = res_s1.valid;
	assign m_tdata    = {2'b00, res_s1.count, res_s1.is_empty, read_value};
	assign m_tuser    = res_s1.status;

endmodule

FILE: rtl/rfq_checker.sv
// Port-level checker of the reversible FIFO queue and its bind to the top level.
`timescale 1ns / 1ps
module rfq_checker import rfq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("accepted operation produced no result");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_EMPTY) |->
		(m_tdata[31:0] == '0 && m_tdata[32] && m_tdata[37:33] == '0))
		else $error("empty status with data or entries");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[31:0] == '0 && !m_tdata[32]))
		else $error("full status with data or empty flag");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result dropped or changed while stalled");

endmodule

bind reversible_fifo_queue rfq_checker u_rfq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
